// ===== sv/segment_intersection_classify_unit_defines.svh =====
// Assertion helpers for the segment intersection classifier.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef SEGMENT_INTERSECTION_CLASSIFY_UNIT_DEFINES_SVH
`define SEGMENT_INTERSECTION_CLASSIFY_UNIT_DEFINES_SVH

// Whenever ante holds in a cycle, cons must hold in the same cycle.
`define SIC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Whenever ante holds in a cycle, cons must hold in the next cycle.
`define SIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sic_pkg.sv =====
package sic_pkg;

  localparam int unsigned REL_WIDTH       = 3;
  localparam int unsigned OUT_TDATA_WIDTH = 8;

  typedef enum logic [REL_WIDTH-1:0] {
    REL_NONE   = 3'd0,
    REL_CROSS  = 3'd1,
    REL_ON_SEG = 3'd2,
    REL_P1     = 3'd3,
    REL_P2     = 3'd4,
    REL_P3     = 3'd5,
    REL_P4     = 3'd6
  } rel_e;

  // Bounding box hits: point pN inside the box of the other segment.
  typedef struct packed {
    logic p4;
    logic p3;
    logic p2;
    logic p1;
  } box_t;

  // Sign of one orientation.
  typedef struct packed {
    logic neg;
    logic zero;
  } sign_t;

endpackage

// ===== sv/sic_diff_stage.sv =====
module sic_diff_stage #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       valid_i,
  output logic                                       ready_o,
  input  logic [8*COORD_WIDTH-1:0]                   coords_i,
  output logic                                       valid_o,
  input  logic                                       ready_i,
  output logic [3:0][3:0][COORD_WIDTH:0]             fac_o,
  output sic_pkg::box_t                              box_o
);
  import sic_pkg::*;

  localparam int unsigned DW = COORD_WIDTH + 1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DW-1:0]          diff_t;

  coord_t p1x, p1y, p2x, p2y, p3x, p3y, p4x, p4y;
  diff_t  e34x, e34y, e31x, e31y, e32x, e32y;
  diff_t  e12x, e12y, e13x, e13y, e14x, e14y;

  logic                         valid_q;
  logic [3:0][3:0][DW-1:0]      fac_d, fac_q;
  box_t                         box_d, box_q;

  function automatic logic between(coord_t a, coord_t b, coord_t q);
    between = (a <= q && q <= b) || (b <= q && q <= a);
  endfunction

  assign p1x = coord_t'(coords_i[0*COORD_WIDTH +: COORD_WIDTH]);
  assign p1y = coord_t'(coords_i[1*COORD_WIDTH +: COORD_WIDTH]);
  assign p2x = coord_t'(coords_i[2*COORD_WIDTH +: COORD_WIDTH]);
  assign p2y = coord_t'(coords_i[3*COORD_WIDTH +: COORD_WIDTH]);
  assign p3x = coord_t'(coords_i[4*COORD_WIDTH +: COORD_WIDTH]);
  assign p3y = coord_t'(coords_i[5*COORD_WIDTH +: COORD_WIDTH]);
  assign p4x = coord_t'(coords_i[6*COORD_WIDTH +: COORD_WIDTH]);
  assign p4y = coord_t'(coords_i[7*COORD_WIDTH +: COORD_WIDTH]);

  assign e34x = diff_t'(p4x) - diff_t'(p3x);
  assign e34y = diff_t'(p4y) - diff_t'(p3y);
  assign e31x = diff_t'(p1x) - diff_t'(p3x);
  assign e31y = diff_t'(p1y) - diff_t'(p3y);
  assign e32x = diff_t'(p2x) - diff_t'(p3x);
  assign e32y = diff_t'(p2y) - diff_t'(p3y);
  assign e12x = diff_t'(p2x) - diff_t'(p1x);
  assign e12y = diff_t'(p2y) - diff_t'(p1y);
  assign e13x = diff_t'(p3x) - diff_t'(p1x);
  assign e13y = diff_t'(p3y) - diff_t'(p1y);
  assign e14x = diff_t'(p4x) - diff_t'(p1x);
  assign e14y = diff_t'(p4y) - diff_t'(p1y);

  // Per orientation: {bx, cy, cx, by}, crossed as bx*cy - cx*by.
  always_comb begin
    fac_d[0] = {e34x, e31y, e31x, e34y};
    fac_d[1] = {e34x, e32y, e32x, e34y};
    fac_d[2] = {e12x, e13y, e13x, e12y};
    fac_d[3] = {e12x, e14y, e14x, e12y};
    box_d.p1 = between(p3x, p4x, p1x) && between(p3y, p4y, p1y);
    box_d.p2 = between(p3x, p4x, p2x) && between(p3y, p4y, p2y);
    box_d.p3 = between(p1x, p2x, p3x) && between(p1y, p2y, p3y);
    box_d.p4 = between(p1x, p2x, p4x) && between(p1y, p2y, p4y);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      fac_q <= fac_d;
      box_q <= box_d;
    end
  end

  assign valid_o = valid_q;
  assign fac_o   = fac_q;
  assign box_o   = box_q;

endmodule

// ===== sv/sic_mult_stage.sv =====
module sic_mult_stage #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic [3:0][3:0][COORD_WIDTH:0]         fac_i,
  input  sic_pkg::box_t                          box_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output logic [3:0][1:0][2*COORD_WIDTH+1:0]     prod_o,
  output sic_pkg::box_t                          box_o
);
  import sic_pkg::*;

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;

  logic                      valid_q;
  logic [3:0][1:0][PW-1:0]   prod_d, prod_q;
  box_t                      box_q;

  // Factor order per orientation, high to low: bx, cy, cx, by.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod_d[k][1] = PW'($signed(fac_i[k][3]) * $signed(fac_i[k][2]));
      prod_d[k][0] = PW'($signed(fac_i[k][1]) * $signed(fac_i[k][0]));
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      prod_q <= prod_d;
      box_q  <= box_i;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;
  assign box_o   = box_q;

endmodule

// ===== sv/sic_sign_stage.sv =====
module sic_sign_stage #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic [3:0][1:0][2*COORD_WIDTH+1:0]     prod_i,
  input  sic_pkg::box_t                          box_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output sic_pkg::sign_t [3:0]                   sign_o,
  output sic_pkg::box_t                          box_o
);
  import sic_pkg::*;

  localparam int unsigned PW = 2 * (COORD_WIDTH + 1);
  localparam int unsigned SW = PW + 1;

  logic                      valid_q;
  logic signed [SW-1:0]      cross_prod [4];
  sign_t [3:0]               sign_d, sign_q;
  box_t                      box_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cross_prod[k]  = SW'($signed(prod_i[k][1])) - SW'($signed(prod_i[k][0]));
      sign_d[k].neg  = cross_prod[k][SW-1];
      sign_d[k].zero = (cross_prod[k] == '0);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      sign_q <= sign_d;
      box_q  <= box_i;
    end
  end

  assign valid_o = valid_q;
  assign sign_o  = sign_q;
  assign box_o   = box_q;

endmodule

// ===== sv/segment_intersection_classify_unit.sv =====
// Classifies two integer segments, p1-p2 and p3-p4, into one relation code: proper crossing,
// segment one wholly on segment two, one end point (p1, p2, p3, p4 in that priority) on the
// other segment, or none. One word is taken every cycle unless back pressure has filled the
// pipeline; each result leaves through four register stages: coordinate differences and
// bounding box tests, the eight exact cross-product multiplies, the orientation subtract and
// sign, and the priority encode into the output register. The multiply stage, (COORD_WIDTH+1)
// by (COORD_WIDTH+1) bits, sets the clock. Back pressure on the result side stalls only the
// stages that are full, so bubbles are squeezed out before the input stops.
`include "segment_intersection_classify_unit_defines.svh"

module segment_intersection_classify_unit #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y
  input  logic [8*COORD_WIDTH-1:0]             s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // relation [2:0], zero pad above
  output logic [sic_pkg::OUT_TDATA_WIDTH-1:0]  m_axis_tdata_o
);
  import sic_pkg::*;

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;

  logic                     d_valid, d_ready;
  logic [3:0][3:0][DW-1:0]  d_fac;
  box_t                     d_box;

  logic                     m_valid, m_ready;
  logic [3:0][1:0][PW-1:0]  m_prod;
  box_t                     m_box;

  logic                     g_valid, g_ready;
  sign_t [3:0]              g_sign;
  box_t                     g_box;

  logic                     out_valid_q;
  rel_e                     rel_d, rel_q;
  logic [3:0]               on_pt;
  logic                     cross_a, cross_b;

  sic_diff_stage #(.COORD_WIDTH(COORD_WIDTH)) u_diff (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid_i),
    .ready_o  (s_axis_tready_o),
    .coords_i (s_axis_tdata_i),
    .valid_o  (d_valid),
    .ready_i  (d_ready),
    .fac_o    (d_fac),
    .box_o    (d_box)
  );

  sic_mult_stage #(.COORD_WIDTH(COORD_WIDTH)) u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid),
    .ready_o (d_ready),
    .fac_i   (d_fac),
    .box_i   (d_box),
    .valid_o (m_valid),
    .ready_i (m_ready),
    .prod_o  (m_prod),
    .box_o   (m_box)
  );

  sic_sign_stage #(.COORD_WIDTH(COORD_WIDTH)) u_sign (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m_valid),
    .ready_o (m_ready),
    .prod_i  (m_prod),
    .box_i   (m_box),
    .valid_o (g_valid),
    .ready_i (g_ready),
    .sign_o  (g_sign),
    .box_o   (g_box)
  );

  // Orientations: 0 = p1 vs p3-p4, 1 = p2 vs p3-p4, 2 = p3 vs p1-p2, 3 = p4 vs p1-p2.
  always_comb begin
    on_pt[0] = g_sign[0].zero && g_box.p1;
    on_pt[1] = g_sign[1].zero && g_box.p2;
    on_pt[2] = g_sign[2].zero && g_box.p3;
    on_pt[3] = g_sign[3].zero && g_box.p4;
    cross_a  = !g_sign[0].zero && !g_sign[1].zero && (g_sign[0].neg != g_sign[1].neg);
    cross_b  = !g_sign[2].zero && !g_sign[3].zero && (g_sign[2].neg != g_sign[3].neg);
    priority if (cross_a && cross_b) begin
      rel_d = REL_CROSS;
    end else if (on_pt[0] && on_pt[1]) begin
      rel_d = REL_ON_SEG;
    end else if (on_pt[0]) begin
      rel_d = REL_P1;
    end else if (on_pt[1]) begin
      rel_d = REL_P2;
    end else if (on_pt[2]) begin
      rel_d = REL_P3;
    end else if (on_pt[3]) begin
      rel_d = REL_P4;
    end else begin
      rel_d = REL_NONE;
    end
  end

  assign g_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (g_ready) begin
      out_valid_q <= g_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (g_ready) begin
      rel_q <= rel_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_WIDTH'(rel_q);

  // Input stops only when every stage is full and the result is held back.
  `SIC_ASSERT_IMPLY(a_stall_only_when_full, !s_axis_tready_o, m_axis_tvalid_o && !m_axis_tready_i, "input stalled while pipeline has room")
  `SIC_ASSERT_IMPLY(a_rel_in_range, m_axis_tvalid_o, m_axis_tdata_o <= OUT_TDATA_WIDTH'(REL_P4), "relation code out of range")
  // A word waiting in the last stage reaches the output register at the next edge.
  `SIC_ASSERT_NEXT(a_last_stage_moves, g_valid && g_ready, m_axis_tvalid_o, "result lost between sign stage and output")

endmodule

// ===== sim/segment_relation_checker.sv =====
module segment_relation_checker #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  input  logic                                 s_axis_tready_i,
  input  logic [8*COORD_WIDTH-1:0]             s_axis_tdata_i,
  input  logic                                 m_axis_tvalid_i,
  input  logic                                 m_axis_tready_i,
  input  logic [sic_pkg::OUT_TDATA_WIDTH-1:0]  m_axis_tdata_i,
  output int unsigned                          mismatch_count_o,
  output int unsigned                          pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sic_pkg::*;

  // Wide enough for an exact difference of two coordinate products.
  typedef logic signed [2*COORD_WIDTH+3:0] wide_t;

  rel_e        expected_relations[$];
  int unsigned mismatch_count = 0;

  initial begin
    mismatch_count_o = 0;
    pending_count_o  = 0;
  end

  function automatic int orient_sign(input wide_t ax, input wide_t ay, input wide_t bx,
                                     input wide_t by, input wide_t cx, input wide_t cy);
    wide_t cross_prod;
    cross_prod = (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
    if (cross_prod > 0) return 1;
    if (cross_prod < 0) return -1;
    return 0;
  endfunction

  function automatic logic in_box(input wide_t ax, input wide_t ay, input wide_t bx,
                                  input wide_t by, input wide_t qx, input wide_t qy);
    wide_t lx, hx, ly, hy;
    lx = (ax < bx) ? ax : bx;
    hx = (ax < bx) ? bx : ax;
    ly = (ay < by) ? ay : by;
    hy = (ay < by) ? by : ay;
    return (lx <= qx) && (qx <= hx) && (ly <= qy) && (qy <= hy);
  endfunction

  function automatic rel_e classify_segments(input logic [8*COORD_WIDTH-1:0] word);
    wide_t c [8];
    int    d1, d2, d3, d4;
    logic  on1, on2, on3, on4;
    for (int i = 0; i < 8; i++) begin
      c[i] = wide_t'($signed(word[i*COORD_WIDTH +: COORD_WIDTH]));
    end
    // c[0..1] p1, c[2..3] p2, c[4..5] p3, c[6..7] p4
    d1 = orient_sign(c[4], c[5], c[6], c[7], c[0], c[1]);
    d2 = orient_sign(c[4], c[5], c[6], c[7], c[2], c[3]);
    d3 = orient_sign(c[0], c[1], c[2], c[3], c[4], c[5]);
    d4 = orient_sign(c[0], c[1], c[2], c[3], c[6], c[7]);
    on1 = (d1 == 0) && in_box(c[4], c[5], c[6], c[7], c[0], c[1]);
    on2 = (d2 == 0) && in_box(c[4], c[5], c[6], c[7], c[2], c[3]);
    on3 = (d3 == 0) && in_box(c[0], c[1], c[2], c[3], c[4], c[5]);
    on4 = (d4 == 0) && in_box(c[0], c[1], c[2], c[3], c[6], c[7]);
    if ((d1 * d2 < 0) && (d3 * d4 < 0)) return REL_CROSS;
    if (on1 && on2) return REL_ON_SEG;
    if (on1) return REL_P1;
    if (on2) return REL_P2;
    if (on3) return REL_P3;
    if (on4) return REL_P4;
    return REL_NONE;
  endfunction

  always @(posedge clk_i) begin
    rel_e                       want;
    logic [OUT_TDATA_WIDTH-1:0] want_word;
    if (rst_ni) begin
      // Retire the result word before queueing a new input word.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_relations.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %0d",
                   $time, m_axis_tdata_i);
          mismatch_count++;
        end else begin
          want      = expected_relations.pop_front();
          want_word = OUT_TDATA_WIDTH'(want);
          if (m_axis_tdata_i !== want_word) begin
            $display("%0t: relation mismatch, expected %0d (%s), got %0d",
                     $time, want_word, want.name(), m_axis_tdata_i);
            mismatch_count++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_relations.push_back(classify_segments(s_axis_tdata_i));
      end
      mismatch_count_o <= mismatch_count;
      pending_count_o  <= expected_relations.size();
    end
  end

endmodule

// ===== sim/tb_segment_intersection_classify_unit.sv =====
module tb_segment_intersection_classify_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sic_pkg::*;

  localparam int unsigned CW           = 16;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned CALM_ITEMS   = 60;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int          CMIN         = -32768;
  localparam int          CMAX         = 32767;

  typedef logic signed [CW-1:0] coord_t;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [8*CW-1:0]            s_axis_tdata  = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned cycle_count = 0;
  int unsigned ready_hold  = 0;
  bit          idle_on     = 1'b1;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  segment_intersection_classify_unit #(
    .COORD_WIDTH(CW)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  segment_relation_checker #(
    .COORD_WIDTH(CW)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_segment_intersection_classify_unit: FAIL");
      $finish;
    end
  end

  // Stall the result side in random bursts, started only while idle_on is set.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (ready_hold != 0) begin
      ready_hold--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      ready_hold = $urandom_range(1, 15) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_segments(input coord_t x1, input coord_t y1, input coord_t x2,
                               input coord_t y2, input coord_t x3, input coord_t y3,
                               input coord_t x4, input coord_t y4);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tdata  <= {y4, x4, y3, x3, y2, x2, y1, x1};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 4))
      0:       return coord_t'(CMIN);
      1:       return coord_t'(CMAX);
      2:       return coord_t'(0);
      3:       return coord_t'(-1);
      default: return coord_t'(1);
    endcase
  endfunction

  task automatic send_random_pair();
    coord_t c [8];
    int     bx, by, dx, dy, k, span;
    case ($urandom_range(0, 9))
      0, 1: begin
        for (int i = 0; i < 8; i++) c[i] = coord_t'($urandom);
      end
      2, 3: begin
        span = ($urandom_range(0, 1) != 0) ? 4 : 40;
        for (int i = 0; i < 8; i++) c[i] = coord_t'(int'($urandom_range(0, 2 * span)) - span);
      end
      4, 5: begin
        // Collinear end points along one random direction.
        bx = int'($urandom_range(0, 40000)) - 20000;
        by = int'($urandom_range(0, 40000)) - 20000;
        dx = int'($urandom_range(0, 6)) - 3;
        dy = int'($urandom_range(0, 6)) - 3;
        for (int j = 0; j < 4; j++) begin
          k        = int'($urandom_range(0, 12)) - 6;
          c[2*j]   = coord_t'(bx + k * dx);
          c[2*j+1] = coord_t'(by + k * dy);
        end
      end
      6: begin
        // Share one end point between the segments.
        for (int i = 0; i < 8; i++) c[i] = coord_t'(int'($urandom_range(0, 16)) - 8);
        k = 2 * $urandom_range(0, 1);
        if ($urandom_range(0, 1) != 0) begin
          c[4] = c[k];
          c[5] = c[k+1];
        end else begin
          c[6] = c[k];
          c[7] = c[k+1];
        end
      end
      7: begin
        for (int i = 0; i < 8; i++) c[i] = pick_extreme();
      end
      8: begin
        // Put one end point at the midpoint of the other segment.
        bx = int'($urandom_range(0, 2000)) - 1000;
        by = int'($urandom_range(0, 2000)) - 1000;
        dx = int'($urandom_range(0, 200)) - 100;
        dy = int'($urandom_range(0, 200)) - 100;
        for (int i = 0; i < 8; i++) c[i] = coord_t'(int'($urandom_range(0, 400)) - 200);
        if ($urandom_range(0, 1) != 0) begin
          c[4] = coord_t'(bx);          c[5] = coord_t'(by);
          c[6] = coord_t'(bx + 2 * dx); c[7] = coord_t'(by + 2 * dy);
          k = 2 * $urandom_range(0, 1);
          c[k] = coord_t'(bx + dx);     c[k+1] = coord_t'(by + dy);
        end else begin
          c[0] = coord_t'(bx);          c[1] = coord_t'(by);
          c[2] = coord_t'(bx + 2 * dx); c[3] = coord_t'(by + 2 * dy);
          k = 4 + 2 * $urandom_range(0, 1);
          c[k] = coord_t'(bx + dx);     c[k+1] = coord_t'(by + dy);
        end
      end
      default: begin
        // Degenerate segment on either side.
        for (int i = 0; i < 8; i++) c[i] = coord_t'(int'($urandom_range(0, 8)) - 4);
        k = 4 * $urandom_range(0, 1);
        c[k+2] = c[k];
        c[k+3] = c[k+1];
      end
    endcase
    send_segments(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_segments(0, 0, 4, 4, 0, 4, 4, 0);
    send_segments(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
    send_segments(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    send_segments(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    send_segments(1, 1, 2, 2, 0, 0, 4, 4);
    send_segments(0, 0, 4, 0, 2, 0, 6, 0);
    send_segments(2, 0, 6, 0, 0, 0, 4, 0);
    send_segments(0, 0, 4, 0, 2, 0, 2, 5);
    send_segments(0, 0, 4, 0, 2, 5, 2, 0);
    send_segments(2, 0, 2, 5, 0, 0, 4, 0);
    send_segments(0, 0, 4, 0, 0, 1, 4, 1);
    send_segments(0, 0, 1, 1, 2, 2, 3, 3);
    send_segments(2, 2, 2, 2, 0, 0, 4, 4);
    send_segments(0, 0, 4, 4, 2, 2, 2, 2);
    send_segments(1, 1, 1, 1, 2, 3, 2, 3);
    send_segments(0, 0, 4, 4, 4, 4, 8, 0);
    send_segments(CMAX, CMAX, CMAX - 1, CMIN, CMIN, 0, CMAX - 2, 0);
    send_segments(-1, -1, 1, 1, -1, 1, 1, -1);
    send_segments(5, -3, -7, 9, -7, 9, 5, -3);
    send_segments(21845, -21846, -21846, 21845, 21845, 21845, -21846, -21846);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (i >= RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
      send_random_pair();
    end
    s_axis_tvalid <= 1'b0;

    do @(posedge clk_i); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb_segment_intersection_classify_unit: PASS");
    end else begin
      $display("tb_segment_intersection_classify_unit: FAIL");
    end
    $finish;
  end

endmodule
